>>> rtl/tms_pkg.sv
// Shared types, constants and reset values for the text marquee scroller.
package tms_pkg;

    localparam int PANEL_WIDTH_DEF = 64;

    localparam int CALC_W = 16;
    localparam int OFFSET_W = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_REQUEST = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_PAUSE = 2'd2;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_LEFT   = 2'd1,
        MODE_BOUNCE = 2'd2,
        MODE_AUTO   = 2'd3
    } t_mode;

    localparam t_mode RST_SCROLL_REQUEST = MODE_AUTO;
    localparam logic [15:0] RST_STEP_INTERVAL = 16'd50;
    localparam logic [15:0] RST_END_PAUSE = 16'd800;

    typedef struct packed {
        t_mode       scroll_request;
        logic [15:0] step_interval_ms;
        logic [15:0] end_pause_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        new_text;
        logic [10:0] text_width;
        logic [10:0] layer_x;
    } t_item;

    typedef struct packed {
        logic [12:0] draw_x;
        t_mode       active_mode;
        logic        done_once;
        logic        still_scrolling;
    } t_result;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                direction_back;
        logic [31:0]         pause_until;
        logic [31:0]         last_step_time;
        logic                completed;
        t_mode               mode_now;
        logic [10:0]         width_latched;
    } t_state;

endpackage

>>> rtl/tms_cfg.sv
// Configuration register file for the text marquee scroller.
module tms_cfg
    import tms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scroll_request <= RST_SCROLL_REQUEST;
            r_cfg.step_interval_ms <= RST_STEP_INTERVAL;
            r_cfg.end_pause_ms <= RST_END_PAUSE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCROLL_REQUEST: r_cfg.scroll_request <= t_mode'(i_cfg_data[1:0]);
                CFG_STEP_INTERVAL:  r_cfg.step_interval_ms <= i_cfg_data;
                CFG_END_PAUSE:      r_cfg.end_pause_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/tms_step.sv
// Scroll state registers and the per-frame update logic.
module tms_step
    import tms_pkg::*;
#(
    parameter int PANEL_WIDTH = PANEL_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic signed [CALC_W-1:0] PANEL = CALC_W'(PANEL_WIDTH);

    t_state r_st;
    t_state n_st;

    logic signed [CALC_W-1:0] lx;
    logic signed [CALC_W-1:0] wl;
    logic signed [CALC_W-1:0] off;
    logic signed [CALC_W-1:0] lim;
    logic signed [CALC_W-1:0] draw;
    logic signed [CALC_W-1:0] stepped_ext;
    logic [OFFSET_W-1:0]      stepped;
    logic                     due;

    always_comb begin
        n_st = r_st;
        lx = CALC_W'($signed(i_item.layer_x));
        if (i_item.new_text) begin
            n_st.width_latched = i_item.text_width;
            n_st.offset = '0;
            n_st.direction_back = 1'b0;
            n_st.pause_until = '0;
            n_st.completed = 1'b0;
            n_st.last_step_time = i_item.now_ms;
            case (i_cfg.scroll_request)
                MODE_NONE:   n_st.mode_now = MODE_NONE;
                MODE_LEFT:   n_st.mode_now = MODE_LEFT;
                MODE_BOUNCE: n_st.mode_now = MODE_BOUNCE;
                default: begin
                    n_st.mode_now = ($signed(CALC_W'(i_item.text_width)) + lx > PANEL) ?
                        MODE_BOUNCE : MODE_NONE;
                end
            endcase
        end

        wl = CALC_W'(n_st.width_latched);
        off = CALC_W'($signed(n_st.offset));
        due = (i_item.now_ms - n_st.last_step_time) >= {16'd0, i_cfg.step_interval_ms};
        lim = wl + lx - PANEL;
        if (lim < 0) begin
            lim = '0;
        end
        stepped = '0;
        stepped_ext = '0;
        draw = lx;

        case (n_st.mode_now)
            MODE_BOUNCE: begin
                draw = lx - off;
                if (i_item.now_ms >= n_st.pause_until && due) begin
                    stepped = n_st.direction_back ? n_st.offset - OFFSET_W'(1)
                                                  : n_st.offset + OFFSET_W'(1);
                    stepped_ext = CALC_W'($signed(stepped));
                    n_st.offset = stepped;
                    n_st.last_step_time = i_item.now_ms;
                    if (!n_st.direction_back && stepped_ext >= lim) begin
                        n_st.offset = lim[OFFSET_W-1:0];
                        n_st.direction_back = 1'b1;
                        n_st.pause_until = i_item.now_ms + {16'd0, i_cfg.end_pause_ms};
                    end else if (n_st.direction_back && stepped_ext <= 0) begin
                        n_st.offset = '0;
                        n_st.direction_back = 1'b0;
                        n_st.pause_until = i_item.now_ms + {16'd0, i_cfg.end_pause_ms};
                        n_st.completed = 1'b1;
                    end
                end
            end
            MODE_LEFT: begin
                draw = PANEL - off;
                if (due) begin
                    n_st.offset = n_st.offset + OFFSET_W'(1);
                    n_st.last_step_time = i_item.now_ms;
                    if (draw + wl < 0) begin
                        n_st.offset = '0;
                        n_st.completed = 1'b1;
                    end
                end
            end
            default: begin
                n_st = i_item.new_text ? n_st : r_st;
            end
        endcase

        o_result.draw_x = draw[12:0];
        o_result.active_mode = n_st.mode_now;
        o_result.done_once = n_st.completed;
        o_result.still_scrolling = (n_st.mode_now == MODE_LEFT || n_st.mode_now == MODE_BOUNCE)
                                   && !n_st.completed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.offset <= '0;
            r_st.direction_back <= 1'b0;
            r_st.pause_until <= '0;
            r_st.last_step_time <= '0;
            r_st.completed <= 1'b0;
            r_st.mode_now <= MODE_NONE;
            r_st.width_latched <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

endmodule

>>> rtl/text_marquee_scroller_core.sv
// Top level of the text marquee scroller: input register, frame update and result register.
// Each input transfer is one render frame and yields exactly one result transfer. The frame
// sits in the input register while the update logic works on it, then moves to the result
// register, from which the result is offered. A new frame is taken in every cycle while the
// output side keeps taking results; while a result waits and the input register is full, the
// input is held off. The scroll state is a single set of registers that advances as a frame
// moves to the result register.
module text_marquee_scroller_core
    import tms_pkg::*;
#(
    parameter int PANEL_WIDTH = PANEL_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // now_ms [31:0], text_width [42:32], layer_x [53:43], zero [55:54]
    input  logic [55:0]            s_axis_tdata,
    // new_text [0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // draw_x [12:0], zero [15:13]
    output logic [15:0]            m_axis_tdata,
    // active_mode [1:0], done_once [2], still_scrolling [3]
    output logic [3:0]             m_axis_tuser
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_item_valid;
    t_result step_result;
    t_result r_result;
    logic    r_result_valid;
    logic    advance;

    tms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tms_step #(
        .PANEL_WIDTH (PANEL_WIDTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_item),
        .o_result (step_result)
    );

    assign advance = r_item_valid && (!r_result_valid || m_axis_tready);
    assign s_axis_tready = !r_item_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_item_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_result_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_result_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.now_ms <= s_axis_tdata[31:0];
            r_item.text_width <= s_axis_tdata[42:32];
            r_item.layer_x <= s_axis_tdata[53:43];
            r_item.new_text <= s_axis_tuser;
        end
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_result_valid;
    assign m_axis_tdata = {3'b000, r_result.draw_x};
    assign m_axis_tuser = {r_result.still_scrolling, r_result.done_once, r_result.active_mode};

endmodule

>>> verif/text_marquee_scroller_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text marquee scroller with its own frame-by-frame predictor.
module text_marquee_scroller_core_tb;
    import tms_pkg::*;

    localparam int PANEL_W = PANEL_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_FRAMES = 360;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;

    text_marquee_scroller_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the configuration and the scroll state.
    t_mode req_mode = RST_SCROLL_REQUEST;
    logic [15:0] step_ms = RST_STEP_INTERVAL;
    logic [15:0] pause_ms = RST_END_PAUSE;
    logic [12:0] scroll_off = '0;
    logic sweep_back = 1'b0;
    logic [31:0] pause_end = '0;
    logic [31:0] last_step = '0;
    logic cycle_done = 1'b0;
    t_mode shown_mode = MODE_NONE;
    logic [10:0] wid_latched = '0;

    t_result expected_frames[$];
    t_result want;
    int errors = 0;
    int cycles = 0;
    int src_gap_max = 18;
    int sink_gap_max = 18;
    int sink_hold = 0;

    function automatic t_result advance_marquee(input logic [31:0] now, input logic fresh,
            input logic [10:0] tw, input logic [10:0] lx_bits);
        int lx;
        int off;
        int lim;
        int draw;
        logic due;
        t_result r;
        lx = int'($signed(lx_bits));
        if (fresh) begin
            wid_latched = tw;
            scroll_off = '0;
            sweep_back = 1'b0;
            pause_end = '0;
            cycle_done = 1'b0;
            last_step = now;
            if (req_mode == MODE_AUTO) begin
                shown_mode = (int'(wid_latched) + lx > PANEL_W) ? MODE_BOUNCE : MODE_NONE;
            end else begin
                shown_mode = req_mode;
            end
        end
        due = (now - last_step) >= {16'd0, step_ms};
        off = int'($signed(scroll_off));
        draw = lx;
        case (shown_mode)
            MODE_BOUNCE: begin
                draw = lx - off;
                if (now >= pause_end && due) begin
                    lim = int'(wid_latched) + lx - PANEL_W;
                    if (lim < 0) lim = 0;
                    scroll_off = 13'(off + (sweep_back ? -1 : 1));
                    off = int'($signed(scroll_off));
                    last_step = now;
                    if (!sweep_back && off >= lim) begin
                        scroll_off = 13'(lim);
                        sweep_back = 1'b1;
                        pause_end = now + {16'd0, pause_ms};
                    end else if (sweep_back && off <= 0) begin
                        scroll_off = '0;
                        sweep_back = 1'b0;
                        pause_end = now + {16'd0, pause_ms};
                        cycle_done = 1'b1;
                    end
                end
            end
            MODE_LEFT: begin
                draw = PANEL_W - off;
                if (due) begin
                    scroll_off = 13'(off + 1);
                    last_step = now;
                    if (draw + int'(wid_latched) < 0) begin
                        scroll_off = '0;
                        cycle_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.draw_x = 13'(draw);
        r.active_mode = shown_mode;
        r.done_once = cycle_done;
        r.still_scrolling = (shown_mode == MODE_LEFT || shown_mode == MODE_BOUNCE) && !cycle_done;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCROLL_REQUEST: req_mode = t_mode'(data[1:0]);
            CFG_STEP_INTERVAL: step_ms = data;
            CFG_END_PAUSE: pause_ms = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input t_mode m, input logic [15:0] step, input logic [15:0] pause);
        write_reg(CFG_SCROLL_REQUEST, {14'd0, m});
        write_reg(CFG_STEP_INTERVAL, step);
        write_reg(CFG_END_PAUSE, pause);
    endtask

    // Valid is left high after a transfer so back-to-back frames never toggle it in one step.
    task automatic send_frame(input logic [31:0] now, input logic fresh, input logic [10:0] tw,
            input logic [10:0] lx);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, lx, tw, now};
        s_axis_tuser <= fresh;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_frames.insert(expected_frames.size(), advance_marquee(now, fresh, tw, lx));
    endtask

    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d frames outstanding", $realtime, expected_frames.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t unexpected result transfer: expected none, actual %h/%h",
                         $realtime, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_frames.pop_front();
                if (m_axis_tdata[12:0] !== want.draw_x) begin
                    errors++;
                    $display("%0t draw_x mismatch: expected %0d actual %0d", $realtime,
                             $signed(want.draw_x), $signed(m_axis_tdata[12:0]));
                end
                if (m_axis_tuser[1:0] !== want.active_mode) begin
                    errors++;
                    $display("%0t active_mode mismatch: expected %0d actual %0d", $realtime,
                             want.active_mode, m_axis_tuser[1:0]);
                end
                if (m_axis_tuser[2] !== want.done_once) begin
                    errors++;
                    $display("%0t done_once mismatch: expected %0b actual %0b", $realtime,
                             want.done_once, m_axis_tuser[2]);
                end
                if (m_axis_tuser[3] !== want.still_scrolling) begin
                    errors++;
                    $display("%0t still_scrolling mismatch: expected %0b actual %0b", $realtime,
                             want.still_scrolling, m_axis_tuser[3]);
                end
            end
        end
    end

    // Result side: random stalls per transfer, plus a long hold-off when a test asks for one.
    initial begin
        int gap;
        int hold;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                hold = sink_hold;
                sink_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            gap = (sink_gap_max == 0) ? 0 : $urandom_range(sink_gap_max, 0);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic test_idle_frames();
        send_frame(32'h0000_0000, 1'b0, 11'h7FF, 11'h400);
        send_frame(32'hFFFF_FFFF, 1'b0, 11'h000, 11'h3FF);
        drain_frames();
    endtask

    task automatic test_directed_scroll();
        // Reset settings: auto with and without overflow, then a layer move mid-sweep.
        send_frame(32'd1000, 1'b1, 11'd100, 11'd0);
        send_frame(32'd1050, 1'b0, 11'd100, 11'd0);
        send_frame(32'd1100, 1'b0, 11'd100, 11'd0);
        send_frame(32'd1200, 1'b1, 11'd64, 11'd0);
        send_frame(32'd1300, 1'b1, 11'd10, 11'd1023);
        send_frame(32'd1350, 1'b0, 11'd10, 11'd1000);
        send_frame(32'd1400, 1'b0, 11'd10, 11'd1000);
        send_frame(32'd1450, 1'b0, 11'd10, -11'sd3);
        drain_frames();
        // No overflow: the text bounces in place and turns round at each step, with a zero end pause.
        configure(MODE_BOUNCE, 16'd0, 16'd0);
        send_frame(32'd5, 1'b1, 11'd10, 11'd0);
        send_frame(32'd6, 1'b0, 11'd10, 11'd0);
        send_frame(32'd7, 1'b0, 11'd10, 11'd0);
        drain_frames();
        configure(MODE_NONE, 16'd0, 16'd0);
        send_frame(32'd9, 1'b1, 11'd300, 11'd20);
        drain_frames();
        configure(MODE_BOUNCE, 16'hFFFF, 16'hFFFF);
        send_frame(32'd0, 1'b1, 11'd65, 11'd0);
        send_frame(32'd65534, 1'b0, 11'd65, 11'd0);
        send_frame(32'd65535, 1'b0, 11'd65, 11'd0);
        send_frame(32'd131069, 1'b0, 11'd65, 11'd0);
        send_frame(32'd131070, 1'b0, 11'd65, 11'd0);
        drain_frames();
        // The pause end wraps past zero, so the unsigned compare lets the next step through.
        configure(MODE_BOUNCE, 16'd0, 16'd800);
        send_frame(32'hFFFF_FFF0, 1'b1, 11'd65, 11'd0);
        send_frame(32'hFFFF_FFF1, 1'b0, 11'd65, 11'd0);
        drain_frames();
        configure(MODE_LEFT, 16'd0, 16'd0);
        send_frame(32'd7, 1'b1, 11'h7FF, 11'h400);
        send_frame(32'd8, 1'b0, 11'h7FF, 11'h400);
        drain_frames();
    endtask

    task automatic test_backpressure();
        configure(MODE_BOUNCE, 16'd0, 16'd2);
        src_gap_max = 0;
        sink_gap_max = 0;
        sink_hold = 150;
        send_frame(32'd100, 1'b1, 11'd72, 11'd0);
        for (int i = 1; i < 24; i++) begin
            send_frame(32'd100 + 32'(i), 1'b0, 11'd72, 11'd0);
        end
        drain_frames();
    endtask

    task automatic test_random_frames();
        int sent;
        int run_len;
        int pick;
        int stride;
        logic [31:0] now;
        logic [10:0] tw;
        logic [10:0] lx;
        logic [15:0] step;
        logic [15:0] pause;
        sent = 0;
        while (sent < RANDOM_FRAMES) begin
            pick = $urandom_range(2, 0);
            src_gap_max = (pick == 0) ? 0 : 18;
            sink_gap_max = (pick == 1) ? 0 : ((pick == 0) ? 0 : 18);
            pick = $urandom_range(9, 0);
            step = (pick < 3) ? 16'd0 : (pick == 9) ? 16'($urandom()) : 16'($urandom_range(8, 1));
            pick = $urandom_range(9, 0);
            pause = (pick < 2) ? 16'd0 : (pick == 9) ? 16'($urandom()) : 16'($urandom_range(30, 1));
            configure(t_mode'($urandom_range(3, 0)), step, pause);
            stride = (step == 0) ? 3 : ((step > 8) ? 16 : 2 * int'(step));
            now = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FF80 + $urandom_range(127, 0) : $urandom();
            pick = $urandom_range(5, 0);
            tw = (pick < 2) ? 11'($urandom_range(20, 0)) :
                 (pick < 5) ? 11'($urandom_range(110, 60)) : 11'($urandom_range(2047, 0));
            lx = ($urandom_range(3, 0) != 0) ? 11'(int'($urandom_range(30, 0)) - 15) :
                 11'($urandom_range(2047, 0));
            run_len = $urandom_range(150, 10);
            send_frame(now, 1'b1, tw, lx);
            sent++;
            for (int i = 0; i < run_len; i++) begin
                now = now + $urandom_range(stride, 0);
                pick = $urandom_range(24, 0);
                if (pick == 0) begin
                    send_frame($urandom(), 1'($urandom_range(1, 0)), 11'($urandom()),
                               11'($urandom()));
                end else begin
                    if (pick == 1) lx = lx + 11'(int'($urandom_range(6, 0)) - 3);
                    if (pick == 2) tw = 11'($urandom_range(110, 0));
                    if (pick == 3) now = now + {16'd0, step};
                    send_frame(now, pick == 2, tw, lx);
                end
                sent++;
            end
            drain_frames();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_frames();
        test_directed_scroll();
        test_backpressure();
        test_random_frames();
        if (errors == 0 && expected_frames.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
